// ===== hdl/canopy_ray_transmittance_top_macros.svh =====
// Assertion macros used by the canopy ray transmittance back end.
`ifndef CANOPY_RAY_TRANSMITTANCE_TOP_MACROS_SVH
`define CANOPY_RAY_TRANSMITTANCE_TOP_MACROS_SVH
// Same-cycle implication, clocked on clk, off during reset.
`define CRT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
// Next-cycle implication, clocked on clk, off during reset.
`define CRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`endif

// ===== hdl/crt_pkg.sv =====
// Types, constants and table function for the canopy ray transmittance block.
package crt_pkg;

  // Status codes
  localparam logic [2:0] ST_ATTEN   = 3'd0;
  localparam logic [2:0] ST_CEIL    = 3'd1;
  localparam logic [2:0] ST_VERT    = 3'd2;
  localparam logic [2:0] ST_HORIZ   = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4;

  // Register indexes
  localparam logic [2:0] REG_LAYER_TOP       = 3'd0;
  localparam logic [2:0] REG_LAYER_BOTTOM    = 3'd1;
  localparam logic [2:0] REG_CONIFER_AREA    = 3'd2;
  localparam logic [2:0] REG_BROADLEAF_AREA  = 3'd3;
  localparam logic [2:0] REG_CONIFER_COEF    = 3'd4;
  localparam logic [2:0] REG_BROADLEAF_COEF  = 3'd5;

  // Reset values
  localparam logic [23:0] RST_LAYER_TOP      = 24'd5120;
  localparam logic [23:0] RST_LAYER_BOTTOM   = 24'd0;
  localparam logic [15:0] RST_CONIFER_COEF   = 16'd4588;
  localparam logic [15:0] RST_BROADLEAF_COEF = 16'd16384;

  // Fixed-point constants
  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic signed [15:0] DIR_ONE = 16'sd16384;
  localparam logic [30:0] LOG2E_Q30   = 31'd1549082005;
  localparam logic [63:0] LN2_Q30     = 64'd744261118;
  localparam int          QUOT_W      = 21;
  localparam int          QDEPTH      = 4;

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] dz;
    logic [23:0] thick;
    logic [14:0] dir;
  } crt_job_t;

  typedef struct packed {
    logic [15:0] c_coef;
    logic [15:0] c_area;
    logic [15:0] b_coef;
    logic [15:0] b_area;
  } crt_coef_t;

  typedef struct packed {
    logic [2:0] status;
    logic       sat;
  } crt_tag_t;

  // exp(-z) in Q2.30 for z in Q2.30, Taylor series through the z^20 term
  function automatic logic [31:0] exp_neg_taylor(input logic [63:0] z);
    logic signed [63:0] sum;
    logic [63:0]        term;
    sum  = 64'sd1 <<< 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= 20; k++) begin
      term = ((term * z) >> 30) / 64'(k);
      if (k % 2 == 1) sum = sum - $signed(term);
      else            sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    return sum[31:0];
  endfunction

endpackage

// ===== hdl/crt_ifs.sv =====
// Channel interfaces: ray input, result output, configuration write.
interface crt_ray_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] exit_height;
  logic signed [15:0] direction_vertical;
  modport source (output valid, exit_height, direction_vertical, input ready);
  modport sink (input valid, exit_height, direction_vertical, output ready);
endinterface

interface crt_result_if;
  logic        valid;
  logic        ready;
  logic [16:0] transmittance;
  logic [2:0]  status;
  modport source (output valid, transmittance, status, input ready);
  modport sink (input valid, transmittance, status, output ready);
endinterface

interface crt_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/crt_front.sv =====
// Front end: classifies each ray and forms the geometry word for the back end.
module crt_front
  import crt_pkg::*;
(
  crt_ray_if.sink            ray,
  input  logic signed [23:0] layer_top,
  input  logic signed [23:0] layer_bottom,
  output crt_job_t           job,
  output logic               job_valid,
  input  logic               job_ready
);

  logic signed [23:0] hp;
  logic signed [24:0] dz_w;
  logic signed [24:0] thick_w;

  assign ray.ready = job_ready;
  assign job_valid = ray.valid;

  // Clamp exit height up to layer bottom
  assign hp      = (ray.exit_height < layer_bottom) ? layer_bottom : ray.exit_height;
  assign dz_w    = {layer_top[23], layer_top} - {hp[23], hp};
  assign thick_w = {layer_top[23], layer_top} - {layer_bottom[23], layer_bottom};

  // Classify in priority order
  always_comb begin
    priority if (ray.exit_height >= layer_top) begin
      job.status = ST_CEIL;
    end else if (ray.direction_vertical == DIR_ONE) begin
      job.status = ST_VERT;
    end else if (ray.direction_vertical == 16'sd0) begin
      job.status = ST_HORIZ;
    end else if (ray.direction_vertical < 16'sd0 || layer_top <= layer_bottom) begin
      job.status = ST_INVALID;
    end else begin
      job.status = ST_ATTEN;
    end
    job.dz    = dz_w[23:0];
    job.thick = thick_w[23:0];
    job.dir   = ray.direction_vertical[14:0];
  end

endmodule

// ===== hdl/crt_queue.sv =====
// Short job queue between front and back end.
module crt_queue
  import crt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  crt_job_t in_job,
  input  logic     in_valid,
  output logic     in_ready,
  output crt_job_t out_job,
  output logic     out_valid,
  input  logic     out_ready
);

  localparam int PW = $clog2(QDEPTH);

  crt_job_t        mem [QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  logic            push;
  logic            pop;

  assign in_ready  = (count != (PW+1)'(QDEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_ready && out_valid;
  assign out_job   = mem[rd_ptr];

  // Store word
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_job;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/crt_back.sv =====
// Back end: optical depth, pipelined divide, exponential and result register.
`include "canopy_ray_transmittance_top_macros.svh"
module crt_back
  import crt_pkg::*;
#(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  crt_coef_t coef,
  input  crt_job_t  job,
  input  logic      job_valid,
  output logic      job_ready,
  crt_result_if.source result
);

  localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
  localparam int MW    = 16 + $clog2(EXP_TABLE_DEPTH + 1);
  localparam int NDIV  = QUOT_W;
  localparam int NST   = 9 + NDIV;
  localparam logic [MW-1:0] DEPTH_V = MW'(EXP_TABLE_DEPTH);

  // 2^-fraction table, Q2.30
  logic [31:0] exp_tab [EXP_TABLE_DEPTH];
  for (genvar i = 0; i < EXP_TABLE_DEPTH; i++) begin : g_tab
    localparam logic [63:0] Z = (64'(i) * LN2_Q30) / EXP_TABLE_DEPTH;
    assign exp_tab[i] = exp_neg_taylor(Z);
  end

  logic           adv;
  logic           v   [NST+1];
  crt_tag_t       tag [NST+1];

  logic [31:0]    p1, p2;
  logic [38:0]    d1, d2, d3, d4;
  logic [23:0]    dz1, dz2;
  logic [32:0]    s2;
  logic [55:0]    plo3;
  logic [23:0]    phi3;
  logic [59:0]    n4, lim4;
  logic [59:0]    r   [NDIV+1];
  logic [38:0]    dd  [NDIV+1];
  logic [NDIV-1:0] q  [NDIV+1];
  logic [51:0]    prod;
  logic [21:0]    y;
  logic [MW-1:0]  idxmul;
  logic [5:0]     n_a, n_b;
  logic [31:0]    tab;
  logic [16:0]    t_out;
  logic [6:0]     sh;
  logic [63:0]    rounded;
  logic           sat_in;
  logic           out_one;
  logic           sat_drop;

  assign adv       = !v[NST] || result.ready;
  assign job_ready = adv;
  assign v[0]      = job_valid;
  assign tag[0]    = '{status: job.status, sat: 1'b0};
  assign sat_in    = (n4 >= lim4);

  // Advance valid and tag lines, set saturation at the compare stage
  for (genvar k = 1; k <= NST; k++) begin : g_line
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (adv) begin
        v[k] <= v[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        tag[k].status <= tag[k-1].status;
        tag[k].sat    <= (k == 5) ? sat_in : tag[k-1].sat;
      end
    end
  end

  // Products, sum, numerator and saturation limit
  always_ff @(posedge clk) begin
    if (adv) begin
      p1   <= coef.c_coef * coef.c_area;
      p2   <= coef.b_coef * coef.b_area;
      d1   <= job.thick * job.dir;
      dz1  <= job.dz;
      s2   <= {1'b0, p1} + {1'b0, p2};
      d2   <= d1;
      dz2  <= dz1;
      plo3 <= s2[31:0] * dz2;
      phi3 <= s2[32] ? dz2 : 24'd0;
      d3   <= d2;
      n4   <= ({4'd0, plo3} + {4'd0, phi3, 32'd0}) << 3;
      lim4 <= ({21'd0, d3} << 20) + ({21'd0, d3} << 19);
      d4   <= d3;
    end
  end

  assign r[0]  = n4;
  assign dd[0] = d4;
  assign q[0]  = '0;

  // Restoring divide, one quotient bit per stage
  for (genvar g = 0; g < NDIV; g++) begin : g_div
    localparam int BIT = NDIV - 1 - g;
    logic [59:0] sub;
    logic        ge;
    assign sub = {21'd0, dd[g]} << BIT;
    assign ge  = (r[g] >= sub);
    always_ff @(posedge clk) begin
      if (adv) begin
        r[g+1]  <= ge ? r[g] - sub : r[g];
        dd[g+1] <= dd[g];
        q[g+1]  <= {q[g][NDIV-2:0], ge};
      end
    end
  end

  // Scale by log2(e), split into shift and table index, look up
  always_ff @(posedge clk) begin
    if (adv) begin
      prod   <= q[NDIV] * LOG2E_Q30;
      y      <= 22'((prod + 52'd536870912) >> 30);
      idxmul <= MW'(y[15:0]) * DEPTH_V;
      n_a    <= y[21:16];
      tab    <= exp_tab[idxmul[16 +: IDX_W]];
      n_b    <= n_a;
      t_out  <= rounded[16:0];
    end
  end

  // Round and shift, select by status
  always_comb begin
    sh      = 7'd14 + {1'b0, n_b};
    rounded = ({32'd0, tab} + (64'd1 << (sh - 7'd1))) >> sh;
    unique case (tag[NST-1].status)
      ST_ATTEN: begin
        if (tag[NST-1].sat || sh >= 7'd40) rounded = 64'd0;
      end
      ST_HORIZ: rounded = 64'd0;
      default:  rounded = {47'd0, ONE_Q16};
    endcase
  end

  assign result.valid         = v[NST];
  assign result.transmittance = t_out;
  assign result.status        = tag[NST].status;

  // Output words that must carry full light, and saturated words about to leave
  assign out_one  = v[NST] && (tag[NST].status == ST_CEIL || tag[NST].status == ST_VERT ||
                               tag[NST].status == ST_INVALID);
  assign sat_drop = adv && v[NST-1] && tag[NST-1].sat && tag[NST-1].status == ST_ATTEN;

  `CRT_ASSERT_IMPL(a_horiz_zero, v[NST] && tag[NST].status == ST_HORIZ, t_out == 17'd0)
  `CRT_ASSERT_IMPL(a_full_pass, out_one, t_out == ONE_Q16)
  `CRT_ASSERT_NEXT(a_sat_zero, sat_drop, t_out == 17'd0)

endmodule

// ===== hdl/canopy_ray_transmittance_top.sv =====
// Top level of the canopy ray transmittance block.
//
// Usage:
//   ray     : input channel, one ray per word (exit height Q15.8,
//             vertical direction Q2.14).
//   result  : output channel, one word per ray (transmittance Q1.16, status).
//   cfg     : register write channel, always ready; write only while idle.
// Throughput: one ray per cycle while the pipeline is not held. Each ray
//   runs through a fixed pipeline: products, numerator, a one-bit-per-stage
//   divide of 21 stages, log2(e) scaling, table lookup and the rounding
//   shift. A ray is written into the queue, read from it into the
//   pipeline and leaves through the result register.
// A four-word queue parts the classifier from the pipeline; when result
//   ready is low with a valid result word, the whole pipeline holds, the
//   queue fills, then ray ready drops.
// Reset: clears the pipeline and queue and loads the register defaults
//   (top 20 m, bottom 0, leaf areas 0, coefficients 0.14 and 0.5).
module canopy_ray_transmittance_top
  import crt_pkg::*;
#(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic         clk,
  input  logic         rst,
  crt_ray_if.sink      ray,
  crt_result_if.source result,
  crt_cfg_if.sink      cfg
);

  logic signed [23:0] layer_top;
  logic signed [23:0] layer_bottom;
  crt_coef_t          coef;
  crt_job_t           f_job;
  logic               f_valid;
  logic               f_ready;
  crt_job_t           b_job;
  logic               b_valid;
  logic               b_ready;

  assign cfg.ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      layer_top    <= RST_LAYER_TOP;
      layer_bottom <= RST_LAYER_BOTTOM;
      coef.c_area  <= '0;
      coef.b_area  <= '0;
      coef.c_coef  <= RST_CONIFER_COEF;
      coef.b_coef  <= RST_BROADLEAF_COEF;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_LAYER_TOP:      layer_top    <= cfg.data;
        REG_LAYER_BOTTOM:   layer_bottom <= cfg.data;
        REG_CONIFER_AREA:   coef.c_area  <= cfg.data[15:0];
        REG_BROADLEAF_AREA: coef.b_area  <= cfg.data[15:0];
        REG_CONIFER_COEF:   coef.c_coef  <= cfg.data[15:0];
        REG_BROADLEAF_COEF: coef.b_coef  <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  crt_front u_front (
    .ray          (ray),
    .layer_top    (layer_top),
    .layer_bottom (layer_bottom),
    .job          (f_job),
    .job_valid    (f_valid),
    .job_ready    (f_ready)
  );

  crt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_job    (f_job),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .out_job   (b_job),
    .out_valid (b_valid),
    .out_ready (b_ready)
  );

  crt_back #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef),
    .job       (b_job),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .result    (result)
  );

endmodule
